// ===== rtl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and constants shared by the circular deque cells and the top level.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int WORD_W = 32;
    localparam int OCC_W  = 5;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_PUSH_REAR  = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_POP_REAR   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        func_t func;
        word_t push_value;
    } cdq_req_t;

    typedef struct packed {
        status_t          status;
        word_t            popped_value;
        logic [OCC_W-1:0] occupancy;
        logic             is_full;
        logic             is_empty;
    } cdq_rsp_t;

    // Operation broadcast to every cell of the row.
    typedef struct packed {
        logic  en;
        func_t func;
        word_t word;
    } cdq_cmd_t;

    // What one cell shows its neighbours: the front-aligned lane, the
    // rear-aligned lane and the occupancy bit of that position.
    typedef struct packed {
        logic  valid;
        word_t a;
        word_t b;
    } cdq_link_t;

endpackage

// ===== rtl/cdq_stream_if.sv =====
// ----------------------------------------------------------------------------
// cdq_stream_if
// Valid/ready channel carrying one payload word per transfer.
// ----------------------------------------------------------------------------
interface cdq_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/cdq_cell.sv =====
// ----------------------------------------------------------------------------
// cdq_cell
// One position of the deque row, holding a front-aligned and a rear-aligned
// copy of the word stored at that distance from either end.
// ----------------------------------------------------------------------------
module cdq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  cdq_pkg::cdq_cmd_t  cmd,
    input  cdq_pkg::cdq_link_t left,
    input  cdq_pkg::cdq_link_t right,
    output cdq_pkg::cdq_link_t state
);

    logic           valid_reg;
    logic           valid_next;
    cdq_pkg::word_t a_reg;
    cdq_pkg::word_t a_next;
    cdq_pkg::word_t b_reg;
    cdq_pkg::word_t b_next;
    logic           first_free;

    // Occupancy is a thermometer, so the first free position is the one
    // whose left neighbour is in use and which is not.
    assign first_free = left.valid && !valid_reg;

    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        valid_next = valid_reg;
        if (cmd.en)
        begin
            unique case (cmd.func)
                cdq_pkg::FUNC_PUSH_FRONT:
                begin
                    a_next     = left.a;
                    valid_next = left.valid;
                    if (first_free)
                    begin
                        b_next = cmd.word;
                    end
                end
                cdq_pkg::FUNC_PUSH_REAR:
                begin
                    b_next     = left.b;
                    valid_next = left.valid;
                    if (first_free)
                    begin
                        a_next = cmd.word;
                    end
                end
                cdq_pkg::FUNC_POP_FRONT:
                begin
                    a_next     = right.a;
                    valid_next = right.valid;
                end
                cdq_pkg::FUNC_POP_REAR:
                begin
                    b_next     = right.b;
                    valid_next = right.valid;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign state = '{valid: valid_reg, a: a_reg, b: b_reg};

endmodule

// ===== rtl/circular_deque_unit.sv =====
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue of DEPTH words built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req channel, each carrying an operation (push front,
// push rear, pop front, pop rear) and a word used by pushes. Every request
// gives exactly one response on the rsp channel with the status, the popped
// word, the occupancy and the full and empty flags.
// A response appears in the cycle after its request transfer, from an output
// register. While the receiver keeps rsp ready high, one request is taken
// every cycle, each cell of the row shifting its word to a neighbour or
// taking the new word in the same cycle, so the rate is one item per cycle.
// If the receiver stalls, the response register holds its contents and req
// ready drops until the response transfer completes; ready stays high while
// the register is being emptied in the same cycle.
// Reset empties the deque at once and drops the response valid flag; the
// stored words and the response payload themselves are not cleared.
// A push to a full deque and a pop from an empty one leave the contents
// untouched and are reported through the status field.
// ----------------------------------------------------------------------------
module circular_deque_unit #(
    parameter int DEPTH = 16
) (
    input logic          clk,
    input logic          rst_n,
    cdq_stream_if.sink   req,
    cdq_stream_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = cdq_pkg::OCC_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    cdq_pkg::cdq_link_t cell_q     [DEPTH];
    cdq_pkg::cdq_link_t cell_left  [DEPTH];
    cdq_pkg::cdq_link_t cell_right [DEPTH];
    logic [DEPTH-1:0]   valid_vec;

    cdq_pkg::cdq_cmd_t  cmd;
    cdq_pkg::func_t     func;
    cdq_pkg::word_t     push_word;
    logic               req_fire;
    logic               is_push;
    logic               refused;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               rsp_valid_reg;
    cdq_pkg::cdq_rsp_t  rsp_reg;
    cdq_pkg::cdq_rsp_t  rsp_next;

    assign func      = req.payload.func;
    assign push_word = req.payload.push_value;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;

    // The head cell sees the incoming word as its left neighbour, the last
    // cell sees an empty position on its right.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign cell_left[i] = '{valid: 1'b1, a: push_word, b: push_word};
        end
        else
        begin : g_mid
            assign cell_left[i] = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign cell_right[i] = '{valid: 1'b0, a: '0, b: '0};
        end
        else
        begin : g_next
            assign cell_right[i] = cell_q[i+1];
        end

        assign valid_vec[i] = cell_q[i].valid;

        cdq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  (cell_left[i]),
            .right (cell_right[i]),
            .state (cell_q[i])
        );
    end

    assign is_push = (func == cdq_pkg::FUNC_PUSH_FRONT) || (func == cdq_pkg::FUNC_PUSH_REAR);
    assign refused = is_push ? valid_vec[DEPTH-1] : !valid_vec[0];

    assign cmd = '{en: req_fire && !refused, func: func, word: push_word};

    always_comb
    begin
        count_next = count_reg;
        if (cmd.en)
        begin
            if (is_push)
            begin
                count_next = count_reg + CNT_ONE;
            end
            else
            begin
                count_next = count_reg - CNT_ONE;
            end
        end
    end

    always_comb
    begin
        rsp_next.status       = cdq_pkg::STATUS_DONE;
        rsp_next.popped_value = '0;
        if (refused)
        begin
            rsp_next.status = is_push ? cdq_pkg::STATUS_FULL : cdq_pkg::STATUS_EMPTY;
        end
        else
        begin
            unique case (func)
                cdq_pkg::FUNC_POP_FRONT: rsp_next.popped_value = cell_q[0].a;
                cdq_pkg::FUNC_POP_REAR:  rsp_next.popped_value = cell_q[0].b;
                default:                 rsp_next.popped_value = '0;
            endcase
        end
        rsp_next.occupancy = OCC_W'(count_next);
        rsp_next.is_full   = (count_next == DEPTH_CNT);
        rsp_next.is_empty  = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (req_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    // The occupancy counter and the cells' thermometer must agree.
    a_count_matches_cells: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_vec))
    ) else $error("occupancy counter disagrees with the cell row");

    // With one word stored, both lanes of the head cell hold that word.
    a_single_word_lanes: assert property (
        @(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_ONE) |-> (cell_q[0].a == cell_q[0].b)
    ) else $error("front and rear lanes differ for a single stored word");

    // A push into a full row is reported as refused.
    a_full_push_refused: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_fire && is_push && valid_vec[DEPTH-1])
            |=> (rsp.valid && rsp.payload.status == cdq_pkg::STATUS_FULL)
    ) else $error("push into a full deque was not refused");

    // A successful pop transfer leaves the occupancy one lower.
    a_pop_count: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_fire && !is_push && valid_vec[0]) |=> (count_reg == $past(count_reg) - CNT_ONE)
    ) else $error("successful pop did not lower the occupancy");

endmodule
